[sv/ring_controller_register_window_top_assert.svh]
// ----------------------------------------------------------------------------
// Register window assertion macros
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef RING_CONTROLLER_REGISTER_WINDOW_TOP_ASSERT_SVH
`define RING_CONTROLLER_REGISTER_WINDOW_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RCRW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("register window assertion failed");
// next-cycle implication
`define RCRW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("register window assertion failed");
`else
`define RCRW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RCRW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[sv/rcrw_pkg.sv]
// ----------------------------------------------------------------------------
// Register window package
// Shared types, access codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package rcrw_pkg;

  localparam int BUFFER_WORDS_DEFAULT = 1024;

  // access kinds
  localparam logic [1:0] REQ_WORD_RD = 2'd0;
  localparam logic [1:0] REQ_WORD_WR = 2'd1;
  localparam logic [1:0] REQ_BYTE_RD = 2'd2;
  localparam logic [1:0] REQ_BYTE_WR = 2'd3;

  localparam logic BANK_ID     = 1'b0;
  localparam logic BANK_STATUS = 1'b1;

  localparam logic [1:0] SLOT_0 = 2'd0;
  localparam logic [1:0] SLOT_1 = 2'd1;
  localparam logic [1:0] SLOT_2 = 2'd2;
  localparam logic [1:0] SLOT_3 = 2'd3;

  // configuration register indexes
  localparam logic CFG_BOARD_PRESENT = 1'b0;
  localparam logic CFG_ID_CODE       = 1'b1;

  localparam logic [15:0] STATUS_RESET = 16'hF806;
  localparam logic [7:0]  CSL_RESET    = 8'hF0;
  localparam logic [7:0]  CSL2_RESET   = 8'hE0;
  localparam logic [7:0]  ID_RESET     = 8'h36;

  localparam logic [15:0] STATUS_KEEP_WR  = 16'hF7FF;
  localparam logic [15:0] STATUS_PRESENT  = 16'h8000;
  localparam logic [15:0] STATUS_DONE_CLR = 16'h6006;
  localparam logic [7:0]  LANE_DONE_CLR   = 8'h40;
  localparam int          CMD_DONE_BIT    = 10;

  typedef struct packed {
    logic [15:0] write_data;
    logic        odd_byte;
    logic [1:0]  register_slot;
    logic        bank;
    logic        win_sel;
    logic [1:0]  req_type;
  } rcrw_req_t;

  typedef struct packed {
    logic capture;   // take request, start buffer read
    logic exec;      // perform access, load result
    logic clr_step;  // clear one buffer word
  } rcrw_cmd_t;

  typedef struct packed {
    logic clr_last;
  } rcrw_sts_t;

endpackage

`default_nettype wire

[sv/rcrw_cfg.sv]
// ----------------------------------------------------------------------------
// Register window configuration port
// APB-style register file for board presence and ID code.
// ----------------------------------------------------------------------------
`default_nettype none

module rcrw_cfg import rcrw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic             board_present,
  output logic [7:0]       id_code
);

  logic       board_present_r, board_present_nxt;
  logic [7:0] id_code_r, id_code_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    board_present_nxt = board_present_r;
    id_code_nxt       = id_code_r;
    if (wr_en) begin
      case (paddr[2])
        CFG_BOARD_PRESENT: board_present_nxt = pwdata[0];
        CFG_ID_CODE:       id_code_nxt       = pwdata[7:0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_present_r <= 1'b1;
      id_code_r       <= ID_RESET;
    end else begin
      board_present_r <= board_present_nxt;
      id_code_r       <= id_code_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      CFG_BOARD_PRESENT: prdata = {31'd0, board_present_r};
      CFG_ID_CODE:       prdata = {24'd0, id_code_r};
      default:           prdata = 32'd0;
    endcase
  end

  assign board_present = board_present_r;
  assign id_code       = id_code_r;

endmodule

`default_nettype wire

[sv/rcrw_dp.sv]
// ----------------------------------------------------------------------------
// Register window datapath
// Window registers, shared word buffer with read-ahead, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcrw_dp import rcrw_pkg::*; #(
  parameter int BUFFER_WORDS = BUFFER_WORDS_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire rcrw_cmd_t cmd,
  output rcrw_sts_t      sts,
  input  wire rcrw_req_t req_in,
  input  wire logic      board_present,
  input  wire logic [7:0] id_code,
  output logic [15:0]    read_data
);

  localparam int AW = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;
  localparam logic [16:0] PTR_LIMIT = 17'(BUFFER_WORDS);
  localparam logic [AW-1:0] CLR_LAST = AW'(BUFFER_WORDS - 1);

  rcrw_req_t   req_r;
  logic [15:0] status_r [2];
  logic [15:0] cmd_r    [2];
  logic [7:0]  csl_r    [2];
  logic [15:0] cmd2_r   [2];
  logic [7:0]  csl2_r   [2];
  logic [15:0] scr1_r   [2];
  logic [15:0] scr2_r   [2];
  logic [15:0] ptr_r    [2];
  logic [15:0] plain_r;
  logic [15:0] ahead_r;
  logic [15:0] brl_r;
  logic [7:0]  bwh_r;
  logic [15:0] rdata_r;
  logic [15:0] mem_q_r;
  logic [AW-1:0] clr_addr_r;
  logic [15:0] mem [BUFFER_WORDS];

  logic        w;
  logic        in_range;
  logic [15:0] fetch;
  logic [7:0]  id_hi;
  logic [15:0] rd_word;
  logic        is_port;
  logic        do_wr;
  logic [15:0] wv;
  logic        port_rd;
  logic        port_wr;
  logic        brl_ld;
  logic        bwh_ld;
  logic [15:0] res;

  assign w        = req_r.win_sel;
  assign in_range = ({1'b0, ptr_r[1]} < PTR_LIMIT);
  assign fetch    = in_range ? mem_q_r : 16'hFFFF;
  assign id_hi    = board_present ? id_code : 8'hFF;
  assign is_port  = (req_r.bank == BANK_STATUS) && (req_r.register_slot == SLOT_3) && w;
  assign port_wr  = do_wr && is_port;

  // side-effect free word view of the addressed register
  always_comb begin
    rd_word = 16'd0;
    if (req_r.bank == BANK_ID) begin
      case (req_r.register_slot)
        SLOT_0:  rd_word = {id_hi, 8'hFF};
        SLOT_1:  rd_word = scr1_r[w];
        SLOT_2:  rd_word = scr2_r[w];
        SLOT_3:  rd_word = ptr_r[w];
        default: rd_word = 16'd0;
      endcase
    end else begin
      case (req_r.register_slot)
        SLOT_0:  rd_word = board_present ? status_r[w] : 16'd0;
        SLOT_1:  rd_word = {cmd_r[w][15:8], csl_r[w]};
        SLOT_2:  rd_word = {cmd2_r[w][15:8], csl2_r[w]};
        SLOT_3:  rd_word = w ? ahead_r : plain_r;
        default: rd_word = 16'd0;
      endcase
    end
  end

  // access decode: result, word write value and port actions
  always_comb begin
    do_wr   = 1'b0;
    wv      = req_r.write_data;
    port_rd = 1'b0;
    brl_ld  = 1'b0;
    bwh_ld  = 1'b0;
    res     = 16'd0;
    case (req_r.req_type)
      REQ_WORD_RD: begin
        res     = rd_word;
        port_rd = is_port;
      end
      REQ_WORD_WR: begin
        do_wr = 1'b1;
      end
      REQ_BYTE_RD: begin
        if (req_r.bank == BANK_ID) begin
          if (req_r.register_slot == SLOT_0) begin
            res = {8'd0, req_r.odd_byte ? (board_present ? 8'h00 : 8'hFF) : id_hi};
          end else begin
            res = {8'd0, req_r.odd_byte ? 8'hFF : rd_word[15:8]};
          end
        end else if (is_port) begin
          if (!req_r.odd_byte) begin
            port_rd = 1'b1;
            brl_ld  = 1'b1;
            res     = {8'd0, ahead_r[15:8]};
          end else begin
            res = {8'd0, brl_r[7:0]};
          end
        end else begin
          res = {8'd0, req_r.odd_byte ? rd_word[7:0] : rd_word[15:8]};
        end
      end
      REQ_BYTE_WR: begin
        if (req_r.bank == BANK_ID) begin
          do_wr = !req_r.odd_byte && (req_r.register_slot != SLOT_0);
          wv    = {req_r.write_data[7:0], 8'd0};
        end else if (is_port) begin
          bwh_ld = !req_r.odd_byte;
          do_wr  = req_r.odd_byte;
          wv     = {bwh_r, req_r.write_data[7:0]};
        end else begin
          do_wr = 1'b1;
          wv    = req_r.odd_byte ? {rd_word[15:8], req_r.write_data[7:0]}
                                 : {req_r.write_data[7:0], rd_word[7:0]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= req_in;
    end
    if (cmd.exec) begin
      rdata_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        status_r[i] <= STATUS_RESET;
        cmd_r[i]    <= 16'd0;
        csl_r[i]    <= CSL_RESET;
        cmd2_r[i]   <= 16'd0;
        csl2_r[i]   <= CSL2_RESET;
        scr1_r[i]   <= 16'd0;
        scr2_r[i]   <= 16'd0;
        ptr_r[i]    <= 16'd0;
      end
      plain_r <= 16'd0;
      ahead_r <= 16'd0;
      brl_r   <= 16'd0;
      bwh_r   <= 8'd0;
    end else if (cmd.exec) begin
      if (port_rd) begin
        ahead_r  <= fetch;
        ptr_r[1] <= ptr_r[1] + 16'd1;
      end
      if (brl_ld) begin
        brl_r <= ahead_r;
      end
      if (bwh_ld) begin
        bwh_r <= req_r.write_data[7:0];
      end
      if (do_wr) begin
        if (req_r.bank == BANK_ID) begin
          case (req_r.register_slot)
            SLOT_1:  scr1_r[w] <= wv;
            SLOT_2:  scr2_r[w] <= wv;
            SLOT_3:  ptr_r[w]  <= wv;
            default: ;
          endcase
        end else begin
          case (req_r.register_slot)
            SLOT_0: begin
              status_r[w] <= (status_r[w] & STATUS_KEEP_WR) |
                             (board_present ? STATUS_PRESENT : 16'd0);
            end
            SLOT_1: begin
              if (wv[CMD_DONE_BIT]) begin
                // command complete: clear busy bits in both lanes
                status_r[w] <= status_r[w] & ~STATUS_DONE_CLR;
                cmd_r[w]    <= 16'd0;
                csl_r[w]    <= csl_r[w] & ~LANE_DONE_CLR;
                cmd2_r[w]   <= 16'd0;
                csl2_r[w]   <= csl2_r[w] & ~LANE_DONE_CLR;
              end else begin
                cmd_r[w] <= wv;
              end
            end
            SLOT_2: cmd2_r[w] <= wv;
            SLOT_3: begin
              if (w) begin
                ptr_r[1] <= ptr_r[1] + 16'd1;
              end else begin
                plain_r <= wv;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  // shared word buffer; read issued on capture, registered and used when the access executes
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_addr_r] <= 16'd0;
    end else if (cmd.exec && port_wr && in_range) begin
      mem[ptr_r[1][AW-1:0]] <= wv;
    end
    if (cmd.capture) begin
      mem_q_r <= mem[ptr_r[1][AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step && !sts.clr_last) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign sts.clr_last = (clr_addr_r == CLR_LAST);
  assign read_data    = rdata_r;

endmodule

`default_nettype wire

[sv/rcrw_ctrl.sv]
// ----------------------------------------------------------------------------
// Register window controller
// Sequences buffer clearing, request capture and access execution.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ring_controller_register_window_top_assert.svh"

module rcrw_ctrl import rcrw_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  wire logic      out_tready,
  output rcrw_cmd_t      cmd,
  input  wire rcrw_sts_t sts
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    cmd.capture  = (state_r == ST_IDLE) && in_tvalid;
    cmd.exec     = (state_r == ST_EXEC) && out_free;
    cmd.clr_step = (state_r == ST_CLEAR);
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  `RCRW_ASSERT_NXT(a_accept_to_exec, clk, rst_n, in_tvalid && in_tready, state_r == ST_EXEC)
  `RCRW_ASSERT_IMP(a_exec_out_free, clk, rst_n, cmd.exec, !out_valid_r || out_tready)
  `RCRW_ASSERT_IMP(a_clear_blocks_in, clk, rst_n, cmd.clr_step, !in_tready && !out_tvalid)
  `RCRW_ASSERT_NXT(a_exec_gives_beat, clk, rst_n, cmd.exec, out_tvalid)

endmodule

`default_nettype wire

[sv/ring_controller_register_window_top.sv]
// Requests are captured in the idle state and executed in the execute state once the output
//   is free, one at a time, with the result registered. The buffer read-ahead takes one registered
//   read of the word buffer in the accept cycle, used by the execute cycle.
// A pending result beat stalls execution only, not the accept of the next request.
// Reset (rst_n, synchronous): registers take their idle values, then the word
//   buffer is cleared one word a cycle, every word from 0 to BUFFER_WORDS-1, with in_tready low.
// ----------------------------------------------------------------------------
// Ring controller register window
// Two-window register bank with shared word buffer and data port.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_controller_register_window_top import rcrw_pkg::*; #(
  parameter int BUFFER_WORDS = BUFFER_WORDS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [0] win_sel, [1] bank, [3:2] register_slot, [4] odd_byte,
  // [20:5] write_data, [23:21] zero
  input  wire logic [23:0] in_tdata,
  // [1:0] req_type
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] read_data
  output logic [15:0]      out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  rcrw_req_t  req;
  rcrw_cmd_t  cmd;
  rcrw_sts_t  sts;
  logic       board_present;
  logic [7:0] id_code;

  always_comb begin
    req.req_type      = in_tuser;
    req.win_sel       = in_tdata[0];
    req.bank          = in_tdata[1];
    req.register_slot = in_tdata[3:2];
    req.odd_byte      = in_tdata[4];
    req.write_data    = in_tdata[20:5];
  end

  rcrw_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (cfg_psel),
    .penable       (cfg_penable),
    .pwrite        (cfg_pwrite),
    .paddr         (cfg_paddr),
    .pwdata        (cfg_pwdata),
    .prdata        (cfg_prdata),
    .pready        (cfg_pready),
    .board_present (board_present),
    .id_code       (id_code)
  );

  rcrw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  rcrw_dp #(
    .BUFFER_WORDS (BUFFER_WORDS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .req_in        (req),
    .board_present (board_present),
    .id_code       (id_code),
    .read_data     (out_tdata)
  );

endmodule

`default_nettype wire

[tb/ring_controller_register_window_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ring controller register window testbench
// Sends bus accesses to both windows and checks each read_data beat against
// a predictor of the register banks, the data port and the shared word
// buffer. It sweeps the board and ID settings and applies back-pressure.
// ----------------------------------------------------------------------------

module ring_controller_register_window_top_tb;
  import rcrw_pkg::*;

  localparam int          BUF_WORDS   = BUFFER_WORDS_DEFAULT;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam logic        WIN_A       = 1'b0;
  localparam logic        WIN_B       = 1'b1;
  localparam logic        LANE_EVEN   = 1'b0;
  localparam logic        LANE_ODD    = 1'b1;

  typedef struct {
    rcrw_req_t   req;
    logic [15:0] rdata;
  } access_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predictor state, one entry per window where the block keeps two
  logic [15:0] st_status [2];
  logic [15:0] st_cmd    [2];
  logic [7:0]  st_lane   [2];
  logic [15:0] st_cmd2   [2];
  logic [7:0]  st_lane2  [2];
  logic [15:0] st_scr1   [2];
  logic [15:0] st_scr2   [2];
  logic [15:0] st_ptr    [2];
  logic [15:0] st_plain;
  logic [15:0] st_ahead;
  logic [15:0] st_byte_latch;
  logic [7:0]  st_byte_hold;
  logic [15:0] st_buf [BUF_WORDS];
  logic        st_present;
  logic [7:0]  st_id;

  access_result_t expected_rdata[$];
  int unsigned    items_sent = 0;
  int unsigned    err_cnt = 0;
  int unsigned    cycle_cnt = 0;
  bit             quiet = 1'b0;
  int unsigned    hold_requests = 0;
  int unsigned    hold_served = 0;
  int unsigned    hold_left = 0;
  int unsigned    stall_left = 0;

  ring_controller_register_window_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [15:0] read_reg_word(logic w, logic bnk, logic [1:0] slot);
    logic [15:0] answered;
    if (bnk == BANK_ID) begin
      case (slot)
        SLOT_0:  return {(st_present ? st_id : 8'hFF), 8'hFF};
        SLOT_1:  return st_scr1[w];
        SLOT_2:  return st_scr2[w];
        default: return st_ptr[w];
      endcase
    end
    case (slot)
      SLOT_0: return st_present ? st_status[w] : 16'h0000;
      SLOT_1: return {st_cmd[w][15:8], st_lane[w]};
      SLOT_2: return {st_cmd2[w][15:8], st_lane2[w]};
      default: begin
        if (w == WIN_A) return st_plain;
        // data port: answer the latch, then refill it from the pointer
        answered = st_ahead;
        st_ahead = (int'(st_ptr[w]) < BUF_WORDS) ? st_buf[st_ptr[w]] : 16'hFFFF;
        st_ptr[w] = st_ptr[w] + 16'd1;
        return answered;
      end
    endcase
  endfunction

  function automatic void write_reg_word(logic w, logic bnk, logic [1:0] slot,
                                         logic [15:0] v);
    if (bnk == BANK_ID) begin
      case (slot)
        SLOT_1:  st_scr1[w] = v;
        SLOT_2:  st_scr2[w] = v;
        SLOT_3:  st_ptr[w] = v;
        default: ;
      endcase
      return;
    end
    case (slot)
      SLOT_0: st_status[w] = (st_status[w] & STATUS_KEEP_WR) |
                             (st_present ? STATUS_PRESENT : 16'h0000);
      SLOT_1: begin
        st_cmd[w] = v;
        if (v[CMD_DONE_BIT]) begin
          st_status[w] = st_status[w] & ~STATUS_DONE_CLR;
          st_cmd[w]    = 16'h0000;
          st_lane[w]   = st_lane[w] & ~LANE_DONE_CLR;
          st_cmd2[w]   = 16'h0000;
          st_lane2[w]  = st_lane2[w] & ~LANE_DONE_CLR;
        end
      end
      SLOT_2: st_cmd2[w] = v;
      default: begin
        if (w == WIN_A) st_plain = v;
        else begin
          if (int'(st_ptr[w]) < BUF_WORDS) st_buf[st_ptr[w]] = v;
          st_ptr[w] = st_ptr[w] + 16'd1;
        end
      end
    endcase
  endfunction

  function automatic logic [7:0] read_reg_byte(logic w, logic bnk, logic [1:0] slot,
                                               logic odd);
    logic [15:0] v;
    if (bnk == BANK_ID) begin
      if (slot == SLOT_0) begin
        if (odd) return st_present ? 8'h00 : 8'hFF;
        return st_present ? st_id : 8'hFF;
      end
      if (odd) return 8'hFF;  // undriven lane
      v = read_reg_word(w, bnk, slot);
      return v[15:8];
    end
    if (w == WIN_B && slot == SLOT_3) begin
      // only the even byte touches the port; the odd one replays the latch
      if (!odd) begin
        st_byte_latch = read_reg_word(w, bnk, slot);
        return st_byte_latch[15:8];
      end
      return st_byte_latch[7:0];
    end
    v = read_reg_word(w, bnk, slot);
    return odd ? v[7:0] : v[15:8];
  endfunction

  function automatic void write_reg_byte(logic w, logic bnk, logic [1:0] slot,
                                         logic odd, logic [7:0] b);
    logic [15:0] held;
    if (bnk == BANK_ID) begin
      if (!odd && slot != SLOT_0) write_reg_word(w, bnk, slot, {b, 8'h00});
      return;
    end
    if (w == WIN_B && slot == SLOT_3) begin
      if (!odd) st_byte_hold = b;
      else write_reg_word(w, bnk, slot, {st_byte_hold, b});
      return;
    end
    held = read_reg_word(w, bnk, slot);
    write_reg_word(w, bnk, slot, odd ? {held[15:8], b} : {b, held[7:0]});
  endfunction

  function automatic logic [15:0] predict_access(rcrw_req_t r);
    logic [15:0] rd;
    rd = 16'h0000;
    case (r.req_type)
      REQ_WORD_RD: rd = read_reg_word(r.win_sel, r.bank, r.register_slot);
      REQ_WORD_WR: write_reg_word(r.win_sel, r.bank, r.register_slot, r.write_data);
      REQ_BYTE_RD: rd = {8'h00, read_reg_byte(r.win_sel, r.bank, r.register_slot,
                                              r.odd_byte)};
      default:     write_reg_byte(r.win_sel, r.bank, r.register_slot, r.odd_byte,
                                  r.write_data[7:0]);
    endcase
    return rd;
  endfunction

  task automatic reset_predictor();
    for (int i = 0; i < 2; i++) begin
      st_status[i] = STATUS_RESET;
      st_cmd[i]    = 16'h0000;
      st_lane[i]   = CSL_RESET;
      st_cmd2[i]   = 16'h0000;
      st_lane2[i]  = CSL2_RESET;
      st_scr1[i]   = 16'h0000;
      st_scr2[i]   = 16'h0000;
      st_ptr[i]    = 16'h0000;
    end
    st_plain      = 16'h0000;
    st_ahead      = 16'h0000;
    st_byte_latch = 16'h0000;
    st_byte_hold  = 8'h00;
    for (int i = 0; i < BUF_WORDS; i++) st_buf[i] = 16'h0000;
    st_present = 1'b1;
    st_id      = ID_RESET;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    access_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_rdata.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing outstanding", out_tdata));
      end else begin
        e = expected_rdata.pop_front();
        if (out_tdata !== e.rdata)
          report_mismatch($sformatf(
            "read_data %h expected %h (type %0d win %0d bank %0d slot %0d odd %0d)",
            out_tdata, e.rdata, e.req.req_type, e.req.win_sel,
            e.req.bank, e.req.register_slot, e.req.odd_byte));
      end
    end
  end

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(99) < 2) begin
      stall_left = $urandom_range(7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_access(input logic [1:0] kind, input logic w, input logic bnk,
                             input logic [1:0] slot, input logic odd,
                             input logic [15:0] data);
    rcrw_req_t r;
    r.req_type      = kind;
    r.win_sel       = w;
    r.bank          = bnk;
    r.register_slot = slot;
    r.odd_byte      = odd;
    r.write_data    = data;
    if (!quiet && $urandom_range(99) < 3) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, r.write_data, r.odd_byte, r.register_slot, r.bank,
                  r.win_sel};
    in_tuser  <= r.req_type;
    do @(posedge clk); while (!in_tready);
    expected_rdata.push_back('{req: r, rdata: predict_access(r)});
    items_sent++;
  endtask

  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_rdata.size() != 0);
  endtask

  task automatic cfg_access(input logic wr, input logic idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (!wr && cfg_prdata !== val)
      report_mismatch($sformatf("register %0d reads %h expected %h", idx, cfg_prdata, val));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_board(input logic present, input logic [7:0] id);
    cfg_access(1'b1, CFG_BOARD_PRESENT, {31'd0, present});
    cfg_access(1'b1, CFG_ID_CODE, {24'd0, id});
    st_present = present;
    st_id      = id;
    cfg_access(1'b0, CFG_BOARD_PRESENT, {31'd0, present});
    cfg_access(1'b0, CFG_ID_CODE, {24'd0, id});
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic rand_noise();
    send_access(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                2'($urandom_range(3)), 1'($urandom_range(1)),
                16'($urandom_range(16'hFFFF)));
  endtask

  // fill part of the buffer through the port, rewind and read it back
  task automatic seq_buffer_run();
    int unsigned pick, n;
    logic [15:0] base;
    pick = $urandom_range(99);
    if (pick < 80)      base = 16'($urandom_range(63));
    else if (pick < 95) base = 16'($urandom_range(BUF_WORDS - 1, BUF_WORDS - 8));
    else                base = 16'($urandom_range(16'hFFFF, 16'hFFF8));
    n = $urandom_range(1, 8);
    send_access(REQ_WORD_WR, WIN_B, BANK_ID, SLOT_3, LANE_EVEN, base);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1)) begin
        send_access(REQ_WORD_WR, WIN_B, BANK_STATUS, SLOT_3, LANE_EVEN,
                    16'($urandom_range(16'hFFFF)));
      end else begin
        send_access(REQ_BYTE_WR, WIN_B, BANK_STATUS, SLOT_3, LANE_EVEN,
                    16'($urandom_range(16'hFFFF)));
        send_access(REQ_BYTE_WR, WIN_B, BANK_STATUS, SLOT_3, LANE_ODD,
                    16'($urandom_range(16'hFFFF)));
      end
    end
    send_access(REQ_WORD_WR, WIN_B, BANK_ID, SLOT_3, LANE_EVEN, base);
    // one extra read: the first answer is whatever the latch held
    for (int i = 0; i <= n; i++) begin
      if ($urandom_range(1)) begin
        send_access(REQ_WORD_RD, WIN_B, BANK_STATUS, SLOT_3, 1'($urandom_range(1)),
                    16'($urandom_range(16'hFFFF)));
      end else begin
        send_access(REQ_BYTE_RD, WIN_B, BANK_STATUS, SLOT_3, LANE_EVEN,
                    16'($urandom_range(16'hFFFF)));
        send_access(REQ_BYTE_RD, WIN_B, BANK_STATUS, SLOT_3, LANE_ODD,
                    16'($urandom_range(16'hFFFF)));
      end
    end
  endtask

  task automatic seq_command();
    logic        w;
    logic [15:0] cmd;
    w   = 1'($urandom_range(1));
    cmd = 16'($urandom_range(16'hFFFF));
    cmd[CMD_DONE_BIT] = 1'($urandom_range(1));
    send_access(REQ_WORD_WR, w, BANK_STATUS, SLOT_0, LANE_EVEN,
                16'($urandom_range(16'hFFFF)));
    send_access($urandom_range(1) ? REQ_WORD_WR : REQ_BYTE_WR, w, BANK_STATUS, SLOT_2,
                1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
    send_access(REQ_WORD_WR, w, BANK_STATUS, SLOT_1, LANE_EVEN, cmd);
    send_access(REQ_WORD_RD, w, BANK_STATUS, SLOT_0, LANE_EVEN,
                16'($urandom_range(16'hFFFF)));
    send_access(REQ_BYTE_RD, w, BANK_STATUS, SLOT_1, 1'($urandom_range(1)),
                16'($urandom_range(16'hFFFF)));
    send_access(REQ_WORD_RD, w, BANK_STATUS, SLOT_2, LANE_EVEN,
                16'($urandom_range(16'hFFFF)));
  endtask

  task automatic seq_scratch();
    logic       w, bnk;
    logic [1:0] slot;
    w    = 1'($urandom_range(1));
    bnk  = 1'($urandom_range(1));
    slot = 2'($urandom_range(3));
    // status slot 3 in the second window is the port; leave it to the buffer runs
    if (bnk == BANK_STATUS && slot == SLOT_3) w = WIN_A;
    send_access($urandom_range(1) ? REQ_WORD_WR : REQ_BYTE_WR, w, bnk, slot,
                1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
    send_access($urandom_range(1) ? REQ_WORD_RD : REQ_BYTE_RD, w, bnk, slot,
                1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
  endtask

  task automatic run_random_mix(input int unsigned quota);
    int unsigned stop_at, pick;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 35)      seq_buffer_run();
      else if (pick < 55) seq_command();
      else if (pick < 75) seq_scratch();
      else                rand_noise();
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_register_map();
    send_access(REQ_WORD_RD, WIN_A, BANK_ID, SLOT_0, LANE_EVEN, 16'h0000);
    send_access(REQ_WORD_WR, WIN_A, BANK_ID, SLOT_1, LANE_EVEN, 16'hFFFF);
    send_access(REQ_WORD_RD, WIN_A, BANK_ID, SLOT_1, LANE_EVEN, 16'h0000);
    send_access(REQ_BYTE_RD, WIN_A, BANK_ID, SLOT_0, LANE_ODD, 16'h0000);
    send_access(REQ_BYTE_RD, WIN_B, BANK_ID, SLOT_2, LANE_ODD, 16'hFFFF);
    send_access(REQ_BYTE_WR, WIN_B, BANK_ID, SLOT_2, LANE_EVEN, 16'h00A5);
    send_access(REQ_BYTE_WR, WIN_B, BANK_ID, SLOT_2, LANE_ODD, 16'h005A);
    send_access(REQ_WORD_RD, WIN_B, BANK_ID, SLOT_2, LANE_EVEN, 16'h0000);
    send_access(REQ_WORD_WR, WIN_A, BANK_STATUS, SLOT_0, LANE_EVEN, 16'h0000);
    send_access(REQ_WORD_RD, WIN_A, BANK_STATUS, SLOT_0, LANE_EVEN, 16'h0000);
    send_access(REQ_BYTE_WR, WIN_A, BANK_STATUS, SLOT_2, LANE_ODD, 16'h005A);
    send_access(REQ_WORD_RD, WIN_A, BANK_STATUS, SLOT_2, LANE_EVEN, 16'h0000);
    // completing command
    send_access(REQ_WORD_WR, WIN_A, BANK_STATUS, SLOT_1, LANE_EVEN, 16'hFFFF);
    send_access(REQ_WORD_RD, WIN_A, BANK_STATUS, SLOT_0, LANE_EVEN, 16'h0000);
    send_access(REQ_WORD_RD, WIN_A, BANK_STATUS, SLOT_1, LANE_EVEN, 16'h0000);
  endtask

  task automatic test_data_port();
    // writes straddle the end of the buffer; the one past it is dropped
    send_access(REQ_WORD_WR, WIN_B, BANK_ID, SLOT_3, LANE_EVEN, 16'(BUF_WORDS - 2));
    send_access(REQ_WORD_WR, WIN_B, BANK_STATUS, SLOT_3, LANE_EVEN, 16'h1234);
    send_access(REQ_BYTE_WR, WIN_B, BANK_STATUS, SLOT_3, LANE_EVEN, 16'h00AB);
    send_access(REQ_BYTE_WR, WIN_B, BANK_STATUS, SLOT_3, LANE_ODD, 16'h00CD);
    send_access(REQ_WORD_WR, WIN_B, BANK_STATUS, SLOT_3, LANE_EVEN, 16'hBEEF);
    send_access(REQ_WORD_WR, WIN_B, BANK_ID, SLOT_3, LANE_EVEN, 16'(BUF_WORDS - 2));
    send_access(REQ_WORD_RD, WIN_B, BANK_STATUS, SLOT_3, LANE_EVEN, 16'h0000);
    send_access(REQ_BYTE_RD, WIN_B, BANK_STATUS, SLOT_3, LANE_EVEN, 16'h0000);
    send_access(REQ_BYTE_RD, WIN_B, BANK_STATUS, SLOT_3, LANE_ODD, 16'h0000);
    send_access(REQ_WORD_RD, WIN_B, BANK_STATUS, SLOT_3, LANE_EVEN, 16'h0000);
    // pointer at the top wraps to zero
    send_access(REQ_WORD_WR, WIN_B, BANK_ID, SLOT_3, LANE_EVEN, 16'hFFFF);
    send_access(REQ_WORD_RD, WIN_B, BANK_STATUS, SLOT_3, LANE_EVEN, 16'h0000);
    send_access(REQ_WORD_RD, WIN_B, BANK_STATUS, SLOT_3, LANE_EVEN, 16'h0000);
    send_access(REQ_WORD_RD, WIN_B, BANK_ID, SLOT_3, LANE_EVEN, 16'h0000);
    send_access(REQ_WORD_WR, WIN_A, BANK_STATUS, SLOT_3, LANE_EVEN, 16'h0000);
    send_access(REQ_WORD_RD, WIN_A, BANK_STATUS, SLOT_3, LANE_EVEN, 16'h0000);
  endtask

  task automatic test_backpressure();
    hold_requests++;
    for (int i = 0; i < 40; i++) rand_noise();
    pause_until_drained();
  endtask

  task automatic test_board_settings();
    logic       present_set [6];
    logic [7:0] id_set      [6];
    present_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    id_set      = '{8'h00, 8'hFF, 8'hFF, 8'h37, 8'h00, 8'h36};
    id_set[4]   = 8'($urandom_range(8'hFF));
    for (int ph = 0; ph < 6; ph++) begin
      pause_until_drained();
      set_board(present_set[ph], id_set[ph]);
      send_access(REQ_WORD_RD, WIN_A, BANK_ID, SLOT_0, LANE_EVEN, 16'h0000);
      send_access(REQ_BYTE_RD, WIN_B, BANK_ID, SLOT_0, LANE_ODD, 16'h0000);
      send_access(REQ_WORD_WR, WIN_B, BANK_STATUS, SLOT_0, LANE_EVEN, 16'h0000);
      send_access(REQ_WORD_RD, WIN_B, BANK_STATUS, SLOT_0, LANE_EVEN, 16'h0000);
      quiet = (ph == 3);  // one stretch with no idling on either side
      run_random_mix(80);
      quiet = 1'b0;
    end
  endtask

  initial begin
    reset_predictor();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_map();
    test_data_port();
    test_backpressure();
    test_board_settings();
    pause_until_drained();
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
